>>> hdl/i2c_ras_pkg.sv
// Shared types and constants of the I2C register access sequencer.
// Used by the front, back and top-level modules; depends on nothing else.
package i2c_ras_pkg;

   localparam int BUDGET_WIDTH   = 16;
   localparam int LIMIT_WIDTH    = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hffff;
   localparam logic [7:0]             READ_BIT    = 8'h01;

   // Register index decoded from the word address.
   localparam logic REG_TIMEOUT_LIMIT = 1'b0;

   // Request action codes.
   localparam logic [1:0] ACTION_TICK  = 2'd0;
   localparam logic [1:0] ACTION_WRITE = 2'd1;
   localparam logic [1:0] ACTION_READ  = 2'd2;

   // Completion status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BUSY    = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_WRITE,
      OP_READ
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_WAIT_FREE = 4'd1,
      ST_SB1       = 4'd2,
      ST_ADDR1     = 4'd3,
      ST_TXE_REG   = 4'd4,
      ST_TXE_NEXT  = 4'd5,
      ST_BTF       = 4'd6,
      ST_SB2       = 4'd7,
      ST_ADDR2     = 4'd8,
      ST_RXNE      = 4'd9
   } step_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       flag_busy;
      logic       flag_sb;
      logic       flag_addr;
      logic       flag_txe;
      logic       flag_btf;
      logic       flag_rxne;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic       gen_start;
      logic       gen_stop;
      logic       ack_enable;
      logic       clear_flags;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rd_data;
      logic       active;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic sb;
      logic addr;
      logic txe;
      logic btf;
      logic rxne;
   } flags_type;

   // Classified transaction handed from the front to the back.
   typedef struct packed {
      op_type     op;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      flags_type  flags;
      logic [7:0] rx_byte;
   } cmd_type;

   // Handshake between the front queue and the back.
   typedef struct packed {
      logic valid;
      logic take;
   } cmd_hs_type;

endpackage

>>> hdl/i2c_ras_front.sv
// Front of the I2C register access sequencer: accepts and classifies
// transactions into a short queue. Depends on i2c_ras_pkg.
module i2c_ras_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  i2c_ras_pkg::req_item_type req_item,
   output i2c_ras_pkg::cmd_type    cmd,
   output logic                    cmd_valid,
   input  logic                    cmd_take
);

   i2c_ras_pkg::cmd_type                      queue_ff [i2c_ras_pkg::QUEUE_DEPTH];
   logic [i2c_ras_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [i2c_ras_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [i2c_ras_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   i2c_ras_pkg::cmd_type                      class_in;
   logic                                      do_push;
   logic                                      do_pop;

   // Codes other than write and read, including the unused one, are ticks.
   always_comb begin
      class_in.dev_addr   = req_item.dev_addr;
      class_in.reg_addr   = req_item.reg_addr;
      class_in.wr_data    = req_item.wr_data;
      class_in.flags.busy = req_item.flag_busy;
      class_in.flags.sb   = req_item.flag_sb;
      class_in.flags.addr = req_item.flag_addr;
      class_in.flags.txe  = req_item.flag_txe;
      class_in.flags.btf  = req_item.flag_btf;
      class_in.flags.rxne = req_item.flag_rxne;
      class_in.rx_byte    = req_item.rx_byte;
      case (req_item.action)
         i2c_ras_pkg::ACTION_WRITE: class_in.op = i2c_ras_pkg::OP_WRITE;
         i2c_ras_pkg::ACTION_READ:  class_in.op = i2c_ras_pkg::OP_READ;
         default:                   class_in.op = i2c_ras_pkg::OP_TICK;
      endcase
   end

   assign full      = (count_ff == i2c_ras_pkg::QUEUE_CNT_W'(i2c_ras_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= class_in;
      end
   end

endmodule

>>> hdl/i2c_ras_back.sv
// Back of the I2C register access sequencer: the step sequencer, the poll
// budget and the result queue. Depends on i2c_ras_pkg.
module i2c_ras_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [i2c_ras_pkg::LIMIT_WIDTH-1:0]   timeout_limit,
   input  i2c_ras_pkg::cmd_type                  cmd,
   input  logic                                  cmd_valid,
   output logic                                  cmd_take,
   output logic                                  empty,
   input  logic                                  pop,
   output i2c_ras_pkg::rsp_item_type             rsp_item
);

   i2c_ras_pkg::step_type                step_ff, step_in;
   logic [i2c_ras_pkg::BUDGET_WIDTH-1:0] budget_ff, budget_in;
   logic                                 read_mode_ff, read_mode_in;
   logic [7:0]                           dev_hold_ff, dev_hold_in;
   logic [7:0]                           reg_hold_ff, reg_hold_in;
   logic [7:0]                           data_hold_ff, data_hold_in;
   logic                                 ack_level_ff, ack_level_in;
   logic                                 met;
   logic                                 is_request;
   i2c_ras_pkg::rsp_item_type            result;

   i2c_ras_pkg::rsp_item_type            outq_ff [i2c_ras_pkg::QUEUE_DEPTH];
   logic [i2c_ras_pkg::QUEUE_PTR_W-1:0]  owr_ptr_ff, owr_ptr_in;
   logic [i2c_ras_pkg::QUEUE_PTR_W-1:0]  ord_ptr_ff, ord_ptr_in;
   logic [i2c_ras_pkg::QUEUE_CNT_W-1:0]  ocount_ff, ocount_in;
   logic                                 out_full;
   logic                                 do_pop;

   assign out_full   = (ocount_ff == i2c_ras_pkg::QUEUE_CNT_W'(i2c_ras_pkg::QUEUE_DEPTH));
   assign cmd_take   = cmd_valid && !out_full;
   assign is_request = (cmd.op == i2c_ras_pkg::OP_WRITE) || (cmd.op == i2c_ras_pkg::OP_READ);

   always_comb begin
      case (step_ff)
         i2c_ras_pkg::ST_WAIT_FREE: met = !cmd.flags.busy;
         i2c_ras_pkg::ST_SB1,
         i2c_ras_pkg::ST_SB2:       met = cmd.flags.sb;
         i2c_ras_pkg::ST_ADDR1,
         i2c_ras_pkg::ST_ADDR2:     met = cmd.flags.addr;
         i2c_ras_pkg::ST_TXE_REG,
         i2c_ras_pkg::ST_TXE_NEXT:  met = cmd.flags.txe;
         i2c_ras_pkg::ST_BTF:       met = cmd.flags.btf;
         i2c_ras_pkg::ST_RXNE:      met = cmd.flags.rxne;
         default:                   met = 1'b0;
      endcase
   end

   // Next state, budget and held request fields.
   always_comb begin
      step_in      = step_ff;
      budget_in    = budget_ff;
      read_mode_in = read_mode_ff;
      dev_hold_in  = dev_hold_ff;
      reg_hold_in  = reg_hold_ff;
      data_hold_in = data_hold_ff;
      ack_level_in = ack_level_ff;
      if (cmd_take) begin
         if (is_request) begin
            if (step_ff == i2c_ras_pkg::ST_IDLE) begin
               dev_hold_in  = cmd.dev_addr;
               reg_hold_in  = cmd.reg_addr;
               data_hold_in = cmd.wr_data;
               read_mode_in = (cmd.op == i2c_ras_pkg::OP_READ);
               budget_in    = i2c_ras_pkg::BUDGET_WIDTH'(timeout_limit);
               step_in      = i2c_ras_pkg::ST_WAIT_FREE;
            end
         end else if (step_ff != i2c_ras_pkg::ST_IDLE) begin
            if (!met) begin
               if (budget_ff == '0) begin
                  step_in = i2c_ras_pkg::ST_IDLE;
               end else begin
                  budget_in = budget_ff - 1'b1;
               end
            end else begin
               case (step_ff)
                  i2c_ras_pkg::ST_WAIT_FREE: begin
                     ack_level_in = 1'b1;
                     step_in      = i2c_ras_pkg::ST_SB1;
                  end
                  i2c_ras_pkg::ST_SB1:      step_in = i2c_ras_pkg::ST_ADDR1;
                  i2c_ras_pkg::ST_ADDR1:    step_in = i2c_ras_pkg::ST_TXE_REG;
                  i2c_ras_pkg::ST_TXE_REG:  step_in = i2c_ras_pkg::ST_TXE_NEXT;
                  i2c_ras_pkg::ST_TXE_NEXT: begin
                     step_in = read_mode_ff ? i2c_ras_pkg::ST_SB2 : i2c_ras_pkg::ST_BTF;
                  end
                  i2c_ras_pkg::ST_BTF: begin
                     ack_level_in = 1'b0;
                     step_in      = i2c_ras_pkg::ST_IDLE;
                  end
                  i2c_ras_pkg::ST_SB2:      step_in = i2c_ras_pkg::ST_ADDR2;
                  i2c_ras_pkg::ST_ADDR2: begin
                     ack_level_in = 1'b0;
                     step_in      = i2c_ras_pkg::ST_RXNE;
                  end
                  default:                  step_in = i2c_ras_pkg::ST_IDLE;
               endcase
            end
         end
      end
   end

   // Actions of the step that the current transaction performs.
   always_comb begin
      result            = '0;
      result.ack_enable = ack_level_in;
      result.active     = (step_in != i2c_ras_pkg::ST_IDLE);
      if (!is_request && step_ff != i2c_ras_pkg::ST_IDLE) begin
         if (!met) begin
            if (budget_ff == '0) begin
               result.done_res = 1'b1;
               result.status   = (step_ff == i2c_ras_pkg::ST_WAIT_FREE) ?
                                 i2c_ras_pkg::STATUS_BUSY : i2c_ras_pkg::STATUS_TIMEOUT;
            end
         end else begin
            case (step_ff)
               i2c_ras_pkg::ST_WAIT_FREE: result.gen_start = 1'b1;
               i2c_ras_pkg::ST_SB1: begin
                  result.clear_flags = 1'b1;
                  result.tx_valid    = 1'b1;
                  result.tx_byte     = dev_hold_ff;
               end
               i2c_ras_pkg::ST_ADDR1:     result.clear_flags = 1'b1;
               i2c_ras_pkg::ST_TXE_REG: begin
                  result.tx_valid = 1'b1;
                  result.tx_byte  = reg_hold_ff;
               end
               i2c_ras_pkg::ST_TXE_NEXT: begin
                  if (read_mode_ff) begin
                     result.gen_start = 1'b1;
                  end else begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = data_hold_ff;
                  end
               end
               i2c_ras_pkg::ST_BTF: begin
                  result.gen_stop = 1'b1;
                  result.done_res = 1'b1;
               end
               i2c_ras_pkg::ST_SB2: begin
                  result.clear_flags = 1'b1;
                  result.tx_valid    = 1'b1;
                  result.tx_byte     = dev_hold_ff | i2c_ras_pkg::READ_BIT;
               end
               i2c_ras_pkg::ST_ADDR2:     result.clear_flags = 1'b1;
               i2c_ras_pkg::ST_RXNE: begin
                  result.rd_data  = cmd.rx_byte;
                  result.gen_stop = 1'b1;
                  result.done_res = 1'b1;
               end
               default: result.clear_flags = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= i2c_ras_pkg::ST_IDLE;
         budget_ff    <= '0;
         read_mode_ff <= 1'b0;
         ack_level_ff <= 1'b0;
         dev_hold_ff  <= '0;
         reg_hold_ff  <= '0;
         data_hold_ff <= '0;
      end else begin
         step_ff      <= step_in;
         budget_ff    <= budget_in;
         read_mode_ff <= read_mode_in;
         ack_level_ff <= ack_level_in;
         dev_hold_ff  <= dev_hold_in;
         reg_hold_ff  <= reg_hold_in;
         data_hold_ff <= data_hold_in;
      end
   end

   // Result queue: decouples the sequencer from a stalled receiver.
   assign empty    = (ocount_ff == '0);
   assign rsp_item = outq_ff[ord_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      owr_ptr_in = cmd_take ? owr_ptr_ff + 1'b1 : owr_ptr_ff;
      ord_ptr_in = do_pop ? ord_ptr_ff + 1'b1 : ord_ptr_ff;
      ocount_in  = ocount_ff;
      if (cmd_take && !do_pop) begin
         ocount_in = ocount_ff + 1'b1;
      end else if (do_pop && !cmd_take) begin
         ocount_in = ocount_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocount_ff  <= '0;
      end else begin
         owr_ptr_ff <= owr_ptr_in;
         ord_ptr_ff <= ord_ptr_in;
         ocount_ff  <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         outq_ff[owr_ptr_ff] <= result;
      end
   end

`ifndef SYNTHESIS
   a_done_ends_request: assert property (@(posedge clock) disable iff (reset)
      (cmd_take && result.done_res) |=> (step_ff == i2c_ras_pkg::ST_IDLE))
      else $error("request finished but sequencer still active");

   a_start_stop_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> !(result.gen_start && result.gen_stop))
      else $error("start and stop requested in the same step");

   a_status_needs_done: assert property (@(posedge clock) disable iff (reset)
      (cmd_take && result.status != i2c_ras_pkg::STATUS_OK) |-> result.done_res)
      else $error("error status without completion");

   a_request_starts_wait: assert property (@(posedge clock) disable iff (reset)
      (cmd_take && is_request && step_ff == i2c_ras_pkg::ST_IDLE)
      |=> (step_ff == i2c_ras_pkg::ST_WAIT_FREE))
      else $error("accepted request did not start the bus-free wait");

   a_stall_holds_step: assert property (@(posedge clock) disable iff (reset)
      !cmd_take |=> $stable(step_ff))
      else $error("sequencer moved without a transaction");
`endif

endmodule

>>> hdl/i2c_register_access_sequencer_unit.sv
// Top level of the I2C register access sequencer: configuration register,
// front classifier queue and back sequencer. Depends on i2c_ras_pkg,
// i2c_ras_front and i2c_ras_back.
//
// Usage: the request channel is a queue input. A transaction is taken at a
// rising edge with push high and full low; it is either a write or read
// request (device address, register address, write data) or a status tick
// that carries the byte-level master's flags and received byte. Every
// transaction produces exactly one result transaction on the result queue,
// which shows the oldest result while empty is low and releases it on pop.
// A result reports the master actions of that step (start, stop, data byte,
// flag clear), the acknowledge level, and on completion the status and the
// byte read.
// A result shows on the ports once its transaction has passed through the
// front queue and been written into the result queue. One transaction per
// cycle is sustained while the receiver keeps popping: the sequencer step is
// a single registered state update, and a two-entry queue on each side of
// it keeps push and pop running every cycle.
// When the receiver stops popping, the result queue fills, the sequencer
// holds, the front queue fills and full rises; nothing is dropped.
// Reset (synchronous, active high) empties both queues, returns the sequencer
// to idle with the acknowledge level low, and sets timeout_limit to 0xffff.
// The user writes the configuration port only while the block is idle; unchecked.
module i2c_register_access_sequencer_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   output logic                                    full,
   input  i2c_ras_pkg::req_item_type               req_item,
   output logic                                    empty,
   input  logic                                    pop,
   output i2c_ras_pkg::rsp_item_type               rsp_item,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [i2c_ras_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [i2c_ras_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [i2c_ras_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                    pready
);

   logic [i2c_ras_pkg::LIMIT_WIDTH-1:0] timeout_limit_ff, timeout_limit_in;
   logic                                reg_index;
   logic                                csr_write;
   i2c_ras_pkg::cmd_type                cmd;
   logic                                cmd_valid;
   logic                                cmd_take;

   // The register file is word addressed; the word index selects the
   // register and byte offsets within the word are ignored.
   assign pready    = 1'b1;
   assign reg_index = paddr[i2c_ras_pkg::CSR_ADDR_WIDTH-1];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      timeout_limit_in = timeout_limit_ff;
      if (csr_write && reg_index == i2c_ras_pkg::REG_TIMEOUT_LIMIT) begin
         timeout_limit_in = pwdata[i2c_ras_pkg::LIMIT_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == i2c_ras_pkg::REG_TIMEOUT_LIMIT) begin
         prdata = i2c_ras_pkg::CSR_DATA_WIDTH'(timeout_limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= i2c_ras_pkg::LIMIT_RESET;
      end else begin
         timeout_limit_ff <= timeout_limit_in;
      end
   end

   // Front: takes request transactions and classifies them into its queue.
   i2c_ras_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take)
   );

   // Back: steps the sequence for each transaction and queues its result.
   i2c_ras_back u_back (
      .clock         (clock),
      .reset         (reset),
      .timeout_limit (timeout_limit_ff),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_take      (cmd_take),
      .empty         (empty),
      .pop           (pop),
      .rsp_item      (rsp_item)
   );

endmodule

>>> test/tb_i2c_register_access_sequencer_unit.sv
// Self-checking testbench for the I2C register access sequencer top level.
// Depends on i2c_ras_pkg and i2c_register_access_sequencer_unit; it predicts
// every result transaction and compares it field by field.
module tb_i2c_register_access_sequencer_unit;

   // Action code three has no name in the package; the block treats it as a tick.
   localparam logic [1:0] ACTION_SPARE = 2'd3;

   // Byte address of the only configuration register.
   localparam logic [i2c_ras_pkg::CSR_ADDR_WIDTH-1:0] LIMIT_ADDR =
      i2c_ras_pkg::CSR_ADDR_WIDTH'(4 * i2c_ras_pkg::REG_TIMEOUT_LIMIT);

   // Flag masks in the order busy, sb, addr, txe, btf, rxne.
   localparam logic [5:0] FLAG_NONE = 6'b000000;
   localparam logic [5:0] FLAG_BUSY = 6'b100000;
   localparam logic [5:0] FLAG_SB   = 6'b010000;
   localparam logic [5:0] FLAG_ADDR = 6'b001000;
   localparam logic [5:0] FLAG_TXE  = 6'b000100;
   localparam logic [5:0] FLAG_BTF  = 6'b000010;
   localparam logic [5:0] FLAG_RXNE = 6'b000001;

   // The longest quiet stretch of a correct run is the deliberate receiver
   // hold, HOLD_CYCLES; WATCHDOG_LIMIT must exceed it.
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int LONG_LIMIT     = 100;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   push  = 1'b0;
   logic                                   full;
   i2c_ras_pkg::req_item_type              req_item = '0;
   logic                                   empty;
   logic                                   pop   = 1'b0;
   i2c_ras_pkg::rsp_item_type              rsp_item;
   logic                                   psel    = 1'b0;
   logic                                   penable = 1'b0;
   logic                                   pwrite  = 1'b0;
   logic [i2c_ras_pkg::CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [i2c_ras_pkg::CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [i2c_ras_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                   pready;

   // Idle percentages of the two sides, changed between phases.
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   // A test asks the receiver for a long hold here; the receiver counts it down.
   int hold_request = 0;
   int hold_left    = 0;

   int          mismatch_count = 0;
   int unsigned quiet_cycles   = 0;

   // Results predicted for accepted transactions, oldest first.
   i2c_ras_pkg::rsp_item_type pending_step_results[$];

   // Predictor state: a private copy of the sequencer and its register.
   i2c_ras_pkg::step_type                seq_state   = i2c_ras_pkg::ST_IDLE;
   logic [i2c_ras_pkg::BUDGET_WIDTH-1:0] poll_budget = '0;
   logic                                 read_req    = 1'b0;
   logic [7:0]                           held_dev    = '0;
   logic [7:0]                           held_reg    = '0;
   logic [7:0]                           held_data   = '0;
   logic                                 ack_on      = 1'b0;
   logic [i2c_ras_pkg::LIMIT_WIDTH-1:0]  poll_limit  = i2c_ras_pkg::LIMIT_RESET;

   i2c_register_access_sequencer_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // Advances the predicted sequencer by one accepted transaction and
   // returns the result that this step must produce.
   function automatic i2c_ras_pkg::rsp_item_type step_sequencer(
      input i2c_ras_pkg::req_item_type it);
      i2c_ras_pkg::rsp_item_type r;
      logic                      met;
      r   = '0;
      met = 1'b0;
      if (it.action == i2c_ras_pkg::ACTION_WRITE || it.action == i2c_ras_pkg::ACTION_READ) begin
         // A request is only taken while idle; otherwise it is dropped silently.
         if (seq_state == i2c_ras_pkg::ST_IDLE) begin
            held_dev    = it.dev_addr;
            held_reg    = it.reg_addr;
            held_data   = it.wr_data;
            read_req    = (it.action == i2c_ras_pkg::ACTION_READ);
            poll_budget = i2c_ras_pkg::BUDGET_WIDTH'(poll_limit);
            seq_state   = i2c_ras_pkg::ST_WAIT_FREE;
         end
      end else if (seq_state != i2c_ras_pkg::ST_IDLE) begin
         case (seq_state)
            i2c_ras_pkg::ST_WAIT_FREE: met = !it.flag_busy;
            i2c_ras_pkg::ST_SB1,
            i2c_ras_pkg::ST_SB2:       met = it.flag_sb;
            i2c_ras_pkg::ST_ADDR1,
            i2c_ras_pkg::ST_ADDR2:     met = it.flag_addr;
            i2c_ras_pkg::ST_TXE_REG,
            i2c_ras_pkg::ST_TXE_NEXT:  met = it.flag_txe;
            i2c_ras_pkg::ST_BTF:       met = it.flag_btf;
            i2c_ras_pkg::ST_RXNE:      met = it.flag_rxne;
            default:                   met = 1'b0;
         endcase
         if (!met) begin
            // One shared budget per request; the first wait reports a busy bus.
            if (poll_budget == '0) begin
               r.done_res = 1'b1;
               r.status   = (seq_state == i2c_ras_pkg::ST_WAIT_FREE) ?
                            i2c_ras_pkg::STATUS_BUSY : i2c_ras_pkg::STATUS_TIMEOUT;
               seq_state  = i2c_ras_pkg::ST_IDLE;
            end else begin
               poll_budget = poll_budget - 1'b1;
            end
         end else begin
            case (seq_state)
               i2c_ras_pkg::ST_WAIT_FREE: begin
                  ack_on      = 1'b1;
                  r.gen_start = 1'b1;
                  seq_state   = i2c_ras_pkg::ST_SB1;
               end
               i2c_ras_pkg::ST_SB1: begin
                  r.clear_flags = 1'b1;
                  r.tx_valid    = 1'b1;
                  r.tx_byte     = held_dev;
                  seq_state     = i2c_ras_pkg::ST_ADDR1;
               end
               i2c_ras_pkg::ST_ADDR1: begin
                  r.clear_flags = 1'b1;
                  seq_state     = i2c_ras_pkg::ST_TXE_REG;
               end
               i2c_ras_pkg::ST_TXE_REG: begin
                  r.tx_valid = 1'b1;
                  r.tx_byte  = held_reg;
                  seq_state  = i2c_ras_pkg::ST_TXE_NEXT;
               end
               i2c_ras_pkg::ST_TXE_NEXT: begin
                  if (read_req) begin
                     r.gen_start = 1'b1;
                     seq_state   = i2c_ras_pkg::ST_SB2;
                  end else begin
                     r.tx_valid = 1'b1;
                     r.tx_byte  = held_data;
                     seq_state  = i2c_ras_pkg::ST_BTF;
                  end
               end
               i2c_ras_pkg::ST_BTF: begin
                  ack_on     = 1'b0;
                  r.gen_stop = 1'b1;
                  r.done_res = 1'b1;
                  seq_state  = i2c_ras_pkg::ST_IDLE;
               end
               i2c_ras_pkg::ST_SB2: begin
                  r.clear_flags = 1'b1;
                  r.tx_valid    = 1'b1;
                  r.tx_byte     = held_dev | i2c_ras_pkg::READ_BIT;
                  seq_state     = i2c_ras_pkg::ST_ADDR2;
               end
               i2c_ras_pkg::ST_ADDR2: begin
                  ack_on        = 1'b0;
                  r.clear_flags = 1'b1;
                  seq_state     = i2c_ras_pkg::ST_RXNE;
               end
               default: begin
                  r.rd_data  = it.rx_byte;
                  r.gen_stop = 1'b1;
                  r.done_res = 1'b1;
                  seq_state  = i2c_ras_pkg::ST_IDLE;
               end
            endcase
         end
      end
      r.ack_enable = ack_on;
      r.active     = (seq_state != i2c_ras_pkg::ST_IDLE);
      return r;
   endfunction

   function automatic i2c_ras_pkg::req_item_type tick_item(input logic [1:0] act,
                                                           input logic [5:0] flags,
                                                           input logic [7:0] rx);
      i2c_ras_pkg::req_item_type it;
      it        = '0;
      it.action = act;
      {it.flag_busy, it.flag_sb, it.flag_addr, it.flag_txe, it.flag_btf, it.flag_rxne} = flags;
      it.rx_byte = rx;
      return it;
   endfunction

   function automatic i2c_ras_pkg::req_item_type request_item(input logic [1:0] act,
                                                              input logic [7:0] dev,
                                                              input logic [7:0] regno,
                                                              input logic [7:0] data);
      i2c_ras_pkg::req_item_type it;
      it          = '0;
      it.action   = act;
      it.dev_addr = dev;
      it.reg_addr = regno;
      it.wr_data  = data;
      return it;
   endfunction

   // Builds a random transaction that mostly follows the predicted sequence:
   // a request when idle, and a tick carrying the awaited flag when active.
   // The rest is noise: ignored requests, spare codes and unmet ticks.
   function automatic i2c_ras_pkg::req_item_type random_item(input int met_pct);
      i2c_ras_pkg::req_item_type it;
      int                        roll;
      it.dev_addr  = 8'($urandom);
      it.reg_addr  = 8'($urandom);
      it.wr_data   = 8'($urandom);
      it.flag_busy = 1'($urandom);
      it.flag_sb   = 1'($urandom);
      it.flag_addr = 1'($urandom);
      it.flag_txe  = 1'($urandom);
      it.flag_btf  = 1'($urandom);
      it.flag_rxne = 1'($urandom);
      it.rx_byte   = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (seq_state == i2c_ras_pkg::ST_IDLE) begin
         if (roll < 80)
            it.action = $urandom_range(0, 1) ? i2c_ras_pkg::ACTION_READ :
                                               i2c_ras_pkg::ACTION_WRITE;
         else if (roll < 92)
            it.action = i2c_ras_pkg::ACTION_TICK;
         else
            it.action = ACTION_SPARE;
      end else begin
         if (roll < 6)
            it.action = $urandom_range(0, 1) ? i2c_ras_pkg::ACTION_READ :
                                               i2c_ras_pkg::ACTION_WRITE;
         else if (roll < 12)
            it.action = ACTION_SPARE;
         else
            it.action = i2c_ras_pkg::ACTION_TICK;
         if ($urandom_range(0, 99) < met_pct) begin
            case (seq_state)
               i2c_ras_pkg::ST_WAIT_FREE: it.flag_busy = 1'b0;
               i2c_ras_pkg::ST_SB1,
               i2c_ras_pkg::ST_SB2:       it.flag_sb   = 1'b1;
               i2c_ras_pkg::ST_ADDR1,
               i2c_ras_pkg::ST_ADDR2:     it.flag_addr = 1'b1;
               i2c_ras_pkg::ST_TXE_REG,
               i2c_ras_pkg::ST_TXE_NEXT:  it.flag_txe  = 1'b1;
               i2c_ras_pkg::ST_BTF:       it.flag_btf  = 1'b1;
               default:                   it.flag_rxne = 1'b1;
            endcase
         end
      end
      return it;
   endfunction

   // Offers one transaction at the falling edge, after a random number of idle
   // cycles, and holds it until the block takes it. The prediction is made at
   // the edge of acceptance, so the expected results keep the accepted order.
   task automatic send_transaction(input i2c_ras_pkg::req_item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_step_results.push_back(step_sequencer(it));
   endtask

   // Stops offering, then waits until every predicted result has been popped
   // and the pipeline has had time to go quiet.
   task automatic settle_block();
      @(negedge clock);
      push <= 1'b0;
      while (pending_step_results.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic read_limit();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= LIMIT_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== i2c_ras_pkg::CSR_DATA_WIDTH'(poll_limit)) begin
         $display("%0t: timeout_limit read expected %0h actual %0h", $time, poll_limit, prdata);
         mismatch_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Writes the poll budget register while the block is quiet, then reads it back.
   task automatic write_limit(input logic [i2c_ras_pkg::CSR_DATA_WIDTH-1:0] value);
      settle_block();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      poll_limit = value[i2c_ras_pkg::LIMIT_WIDTH-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      read_limit();
   endtask

   // Random limit with junk in the unused upper bits of the write data.
   function automatic logic [i2c_ras_pkg::CSR_DATA_WIDTH-1:0] pick_limit();
      logic [i2c_ras_pkg::LIMIT_WIDTH-1:0] lim;
      case ($urandom_range(0, 3))
         0:       lim = '0;
         1:       lim = i2c_ras_pkg::LIMIT_WIDTH'($urandom_range(1, 4));
         2:       lim = i2c_ras_pkg::LIMIT_WIDTH'($urandom_range(5, 40));
         default: lim = i2c_ras_pkg::LIMIT_WIDTH'($urandom);
      endcase
      return {16'($urandom), lim};
   endfunction

   task automatic test_reset_value();
      read_limit();
   endtask

   // Ticks and spare codes while idle must do nothing.
   task automatic test_idle_ticks();
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, 6'b111111, 8'hff));
      send_transaction(tick_item(ACTION_SPARE, FLAG_NONE, 8'h00));
   endtask

   // A full write with two unmet ticks, a request while active and a spare code tick.
   task automatic test_write_sequence();
      send_transaction(request_item(i2c_ras_pkg::ACTION_WRITE, 8'hff, 8'hff, 8'hff));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_BUSY, 8'h00));
      send_transaction(request_item(i2c_ras_pkg::ACTION_READ, 8'h12, 8'h34, 8'h56));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_NONE, 8'h00));
      send_transaction(tick_item(ACTION_SPARE, FLAG_SB, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_ADDR, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_TXE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_TXE | FLAG_BUSY, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_NONE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_BTF, 8'h00));
   endtask

   // A full read: repeated start, address with the read bit, captured byte.
   task automatic test_read_sequence();
      send_transaction(request_item(i2c_ras_pkg::ACTION_READ, 8'h00, 8'h00, 8'haa));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_NONE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_SB, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_ADDR, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_TXE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_TXE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_SB | FLAG_RXNE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_ADDR, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_RXNE, 8'hff));
   endtask

   // With a zero limit no unmet tick is allowed: the bus-busy wait ends with busy
   // status, a later wait with timeout and no stop; limit one allows one unmet tick.
   task automatic test_budget_exhaustion();
      write_limit('0);
      send_transaction(request_item(i2c_ras_pkg::ACTION_WRITE, 8'h40, 8'h01, 8'h02));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_BUSY, 8'h00));
      send_transaction(request_item(i2c_ras_pkg::ACTION_READ, 8'h40, 8'h01, 8'h02));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_NONE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_NONE, 8'h00));
      write_limit(32'h0000_0001);
      send_transaction(request_item(i2c_ras_pkg::ACTION_WRITE, 8'h40, 8'h01, 8'h02));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_NONE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_NONE, 8'h00));
      send_transaction(tick_item(i2c_ras_pkg::ACTION_TICK, FLAG_BUSY, 8'h00));
   endtask

   // A long limit, run all the way down on a bus that stays busy.
   task automatic test_full_budget();
      i2c_ras_pkg::req_item_type it;
      write_limit(i2c_ras_pkg::CSR_DATA_WIDTH'(LONG_LIMIT));
      send_transaction(request_item(i2c_ras_pkg::ACTION_WRITE, 8'h5a, 8'ha5, 8'h3c));
      repeat (LONG_LIMIT + 1) begin
         it           = random_item(0);
         it.action    = i2c_ras_pkg::ACTION_TICK;
         it.flag_busy = 1'b1;
         send_transaction(it);
      end
   endtask

   // The receiver stops popping for a long stretch while transactions keep
   // coming, so both queues fill and full rises.
   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      repeat (40) send_transaction(random_item(90));
   endtask

   task automatic test_random(input int count);
      repeat (3) begin
         write_limit(pick_limit());
         repeat (count / 3) send_transaction(random_item(85));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      rsp_idle_pct  = 64;
      test_reset_value();
      test_idle_ticks();
      test_write_sequence();
      test_read_sequence();
      test_budget_exhaustion();
      test_random(420);
      test_backpressure();

      send_idle_pct = 64;
      rsp_idle_pct  = 21;
      test_random(420);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_full_budget();
      test_random(420);

      settle_block();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Receiver side: pop is driven at the falling edge, either by a pending
   // long hold counted down here, or by the random idle rate.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left--;
      end else begin
         pop <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] exp_val,
                                       input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   // Every popped result transaction is compared with the oldest prediction.
   always @(posedge clock) begin
      i2c_ras_pkg::rsp_item_type exp_rsp;
      if (!reset && pop && !empty) begin
         if (pending_step_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual %0h", $time, rsp_item);
            mismatch_count++;
         end else begin
            exp_rsp = pending_step_results.pop_front();
            check_field("gen_start", 8'(exp_rsp.gen_start), 8'(rsp_item.gen_start));
            check_field("gen_stop", 8'(exp_rsp.gen_stop), 8'(rsp_item.gen_stop));
            check_field("ack_enable", 8'(exp_rsp.ack_enable), 8'(rsp_item.ack_enable));
            check_field("clear_flags", 8'(exp_rsp.clear_flags), 8'(rsp_item.clear_flags));
            check_field("tx_valid", 8'(exp_rsp.tx_valid), 8'(rsp_item.tx_valid));
            check_field("tx_byte", exp_rsp.tx_byte, rsp_item.tx_byte);
            check_field("done_res", 8'(exp_rsp.done_res), 8'(rsp_item.done_res));
            check_field("status", 8'(exp_rsp.status), 8'(rsp_item.status));
            check_field("rd_data", exp_rsp.rd_data, rsp_item.rd_data);
            check_field("active", 8'(exp_rsp.active), 8'(rsp_item.active));
         end
      end
   end

   // Watchdog: ends the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
